// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent checks used by the cache top module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition implies a consequence at the next clock edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/lrukv_pkg.sv
// ----------------------------------------------------------------------------
// lrukv_pkg
// Types and constants of the LRU key/value cache.
// ----------------------------------------------------------------------------
package lrukv_pkg;

	localparam int ENTRIES_DEF     = 16;
	localparam int KEY_WIDTH_DEF   = 32;
	localparam int VALUE_WIDTH_DEF = 32;

	localparam int FIELD_W = 32;
	localparam int PDATA_W = 32;
	localparam int PADDR_W = 3;
	localparam int CAP_W   = 5;
	// count and limit bus width, enough for the largest build (256 entries)
	localparam int CTL_W   = 9;

	localparam logic [CAP_W-1:0] CAP_RESET    = 5'd16;
	localparam logic [0:0]       REG_CAPACITY = 1'b0;

	localparam logic ACT_GET = 1'b0;
	localparam logic ACT_PUT = 1'b1;

	typedef struct packed {
		logic                      action;
		logic signed [FIELD_W-1:0] lookup_key;
		logic signed [FIELD_W-1:0] store_value;
	} req_t;

	typedef struct packed {
		logic                      hit;
		logic signed [FIELD_W-1:0] read_data;
		logic                      evicted;
		logic signed [FIELD_W-1:0] evicted_key;
	} rsp_t;

	// broadcast to every cell of the recency chain
	typedef struct packed {
		logic             upd;    // update cycle: cells at or below limit shift
		logic [CTL_W-1:0] limit;  // last position that takes its neighbor's entry
		logic [CTL_W-1:0] count;  // positions below count hold live entries
	} cell_ctl_t;

endpackage

// File: rtl/lru_key_value_cache_top.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache_top
// Fully associative key/value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Requests (get or put) come in on req_valid/req_ready with payload req;
// one response per request leaves on rsp_valid/rsp_ready with payload rsp.
// The capacity register sits on the APB port at byte address 0, pready is
// tied high.
// Entries live in a chain of cells ordered by recency, most recent at the
// head. A request has a lookup cycle in which every cell compares its key
// and the response is registered (rsp_valid rises as the lookup completes,
// together with the move to the update cycle), then an update cycle in which,
// on a hit or a put, the cells up to the hit, victim or free position take
// their neighbor's entry and the head takes the new one. req_ready is high
// again in the update cycle, so a new request waits while one is in lookup.
// If the receiver stalls, the next request waits in its lookup cycle until
// the response register frees; req_ready stays low meanwhile.
// Reset empties the cache (entry count zero) and sets capacity to 16; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lru_key_value_cache_top import lrukv_pkg::*; #(
	parameter int ENTRIES     = ENTRIES_DEF,
	parameter int KEY_WIDTH   = KEY_WIDTH_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  req_t               req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output rsp_t               rsp,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	localparam int CNT_W = $clog2(ENTRIES + 1);

	typedef enum logic [1:0] {ST_IDLE, ST_LOOKUP, ST_UPDATE} state_t;

	state_t                 state_q;
	logic                   rsp_valid_q;
	rsp_t                   rsp_q;
	req_t                   req_q;
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       eff_cap;

	logic                   upd_s1;
	logic                   inc_s1;
	logic [CNT_W-1:0]       limit_s1;
	logic [KEY_WIDTH-1:0]   new_key_s1;
	logic [VALUE_WIDTH-1:0] new_val_s1;

	logic [KEY_WIDTH-1:0]   cell_key [ENTRIES];
	logic [VALUE_WIDTH-1:0] cell_val [ENTRIES];
	logic [ENTRIES-1:0]     match_vec;
	logic [ENTRIES-1:0]     tail_vec;
	cell_ctl_t              ctl;

	logic                   go;
	logic                   is_put;
	logic                   hit;
	logic                   full;
	logic                   evict;
	logic [CNT_W-1:0]       hit_pos;
	logic [CNT_W-1:0]       limit;
	logic [VALUE_WIDTH-1:0] hit_val;
	logic [KEY_WIDTH-1:0]   tail_key;
	logic [KEY_WIDTH-1:0]   probe_key;
	logic [VALUE_WIDTH-1:0] put_val;
	logic [63:0]            key64;
	logic [63:0]            val64;
	logic [63:0]            hit_val64;
	logic [63:0]            tail_key64;

	assign pready = 1'b1;

	lrukv_cfg #(.ENTRIES(ENTRIES)) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.eff_cap (eff_cap)
	);

	// keys and values kept in their low KEY_WIDTH / VALUE_WIDTH bits
	assign key64     = 64'($unsigned(req_q.lookup_key));
	assign val64     = 64'($unsigned(req_q.store_value));
	assign probe_key = key64[KEY_WIDTH-1:0];
	assign put_val   = val64[VALUE_WIDTH-1:0];

	assign ctl.upd   = (state_q == ST_UPDATE) && upd_s1;
	assign ctl.limit = CTL_W'(limit_s1);
	assign ctl.count = CTL_W'(count_q);

	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		logic [KEY_WIDTH-1:0]   up_key;
		logic [VALUE_WIDTH-1:0] up_val;
		if (g == 0) begin : g_head
			assign up_key = new_key_s1;
			assign up_val = new_val_s1;
		end else begin : g_link
			assign up_key = cell_key[g-1];
			assign up_val = cell_val[g-1];
		end
		lrukv_cell #(
			.INDEX       (g),
			.KEY_WIDTH   (KEY_WIDTH),
			.VALUE_WIDTH (VALUE_WIDTH)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.probe_key  (probe_key),
			.prev_key   (up_key),
			.prev_value (up_val),
			.key        (cell_key[g]),
			.value      (cell_val[g]),
			.match      (match_vec[g]),
			.tail       (tail_vec[g])
		);
	end

	// at most one cell matches, so OR-ing selects it
	always_comb begin
		hit_val  = '0;
		hit_pos  = '0;
		tail_key = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (match_vec[i]) begin
				hit_val = hit_val | cell_val[i];
				hit_pos = hit_pos | CNT_W'(i);
			end
			if (tail_vec[i]) begin
				tail_key = tail_key | cell_key[i];
			end
		end
	end

	assign hit        = |match_vec;
	assign is_put     = req_q.action == ACT_PUT;
	assign full       = count_q >= eff_cap;
	assign evict      = is_put && !hit && full;
	assign hit_val64  = 64'(hit_val);
	assign tail_key64 = 64'(tail_key);

	// shift range: up to the hit, up to the evicted tail, or into the free slot
	always_comb begin
		if (hit) begin
			limit = hit_pos;
		end else if (full) begin
			limit = count_q - CNT_W'(1);
		end else begin
			limit = count_q;
		end
	end

	assign go        = (state_q == ST_LOOKUP) && (!rsp_valid_q || rsp_ready);
	assign req_ready = state_q != ST_LOOKUP;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			count_q     <= '0;
			upd_s1      <= 1'b0;
			inc_s1      <= 1'b0;
		end else begin
			if (go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= ST_LOOKUP;
					end
				end
				ST_LOOKUP: begin
					if (go) begin
						state_q <= ST_UPDATE;
						upd_s1  <= hit || is_put;
						inc_s1  <= is_put && !hit && !full;
					end
				end
				ST_UPDATE: begin
					if (inc_s1) begin
						count_q <= count_q + CNT_W'(1);
					end
					state_q <= req_valid ? ST_LOOKUP : ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_q <= req;
		end
		if (go) begin
			limit_s1          <= limit;
			new_key_s1        <= probe_key;
			new_val_s1        <= is_put ? put_val : hit_val;
			rsp_q.hit         <= hit;
			rsp_q.read_data   <= (!is_put && hit) ? hit_val64[FIELD_W-1:0] : '1;
			rsp_q.evicted     <= evict;
			rsp_q.evicted_key <= evict ? tail_key64[FIELD_W-1:0] : '0;
		end
	end

	`ASSERT_CLK(a_count_bound, 32'(count_q) <= ENTRIES, "entry count above entry total")
	`ASSERT_CLK(a_unique_key, (state_q != ST_LOOKUP) || $onehot0(match_vec),
		"key held by more than one cell")
	`ASSERT_CLK(a_count_mono, count_q >= $past(count_q), "entry count decreased")
	`ASSERT_NEXT(a_update_once, state_q == ST_UPDATE, state_q != ST_UPDATE,
		"chain update lasted more than one cycle")
	`ASSERT_CLK(a_evict_miss, !(rsp_valid_q && rsp_q.evicted && rsp_q.hit),
		"eviction reported on a hit")

endmodule

// File: rtl/lrukv_cell.sv
// ----------------------------------------------------------------------------
// lrukv_cell
// One position of the recency chain: holds a key/value pair, compares the
// probe key, and takes its upper neighbor's pair when the chain shifts.
// ----------------------------------------------------------------------------
module lrukv_cell import lrukv_pkg::*; #(
	parameter int INDEX       = 0,
	parameter int KEY_WIDTH   = KEY_WIDTH_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  cell_ctl_t              ctl,
	input  logic [KEY_WIDTH-1:0]   probe_key,
	input  logic [KEY_WIDTH-1:0]   prev_key,
	input  logic [VALUE_WIDTH-1:0] prev_value,
	output logic [KEY_WIDTH-1:0]   key,
	output logic [VALUE_WIDTH-1:0] value,
	output logic                   match,
	output logic                   tail
);

	logic [KEY_WIDTH-1:0]   key_q;
	logic [VALUE_WIDTH-1:0] value_q;
	logic                   active;
	logic                   shift;

	// position equals recency rank; live positions are 0 .. count-1
	assign active = ctl.count > CTL_W'(INDEX);
	assign tail   = ctl.count == CTL_W'(INDEX + 1);
	assign match  = active && (key_q == probe_key);
	assign shift  = ctl.upd && (ctl.limit >= CTL_W'(INDEX));

	always_ff @(posedge clk) begin
		if (shift) begin
			key_q   <= prev_key;
			value_q <= prev_value;
		end
	end

	assign key   = key_q;
	assign value = value_q;

endmodule

// File: rtl/lrukv_cfg.sv
// ----------------------------------------------------------------------------
// lrukv_cfg
// APB capacity register and its clamp to the range 1 .. built entry count.
// ----------------------------------------------------------------------------
module lrukv_cfg import lrukv_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF,
	localparam int CNT_W  = $clog2(ENTRIES + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic [CNT_W-1:0]   eff_cap
);

	logic [CAP_W-1:0] cap_q;
	logic             sel_cap;

	// word index, byte offset ignored
	assign sel_cap = paddr[PADDR_W-1:2] == REG_CAPACITY;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (psel && penable && pwrite && sel_cap) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (sel_cap) begin
			prdata = PDATA_W'(cap_q);
		end
	end

	always_comb begin
		if (cap_q == '0) begin
			eff_cap = CNT_W'(1);
		end else if (32'(cap_q) > ENTRIES) begin
			eff_cap = CNT_W'(ENTRIES);
		end else begin
			eff_cap = CNT_W'(cap_q);
		end
	end

endmodule
